FILE: rtl/core/positional_list_sort_engine_assert.svh
`ifndef POSITIONAL_LIST_SORT_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_SORT_ENGINE_ASSERT_SVH
// Assertion helpers for the list engine.
`ifndef ASSERT_OFF
`define PLSE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PLSE_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PLSE_ASSERT(label, clk, rst, prop, msg)
`define PLSE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/plse_pkg.sv
package plse_pkg;
   localparam int CAPACITY = 128;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_REMKEY = 3'd2;
   localparam logic [2:0] OP_SEARCH = 3'd3;
   localparam logic [2:0] OP_SORT   = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_BADPOS   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [2:0]         operation;
      logic [6:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] read_value;
      logic [6:0]         found_position;
      logic [7:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [31:0]      wdata;
      logic [IDX_W-1:0] raddr;
   } mem_ctl_type;
endpackage

FILE: rtl/core/plse_ram.sv
module plse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/core/plse_ctrl.sv
`include "positional_list_sort_engine_assert.svh"
module plse_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  plse_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output plse_pkg::rsp_type     rsp_data,
   output plse_pkg::mem_ctl_type mem_ctl,
   input  logic [31:0]           mem_rdata
);
   import plse_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_INS    = 4'd1;  // shift up, one read per step
   localparam logic [3:0] S_DROP   = 4'd2;  // shift down
   localparam logic [3:0] S_FIND   = 4'd3;  // linear scan
   localparam logic [3:0] S_READ   = 4'd4;
   localparam logic [3:0] S_SOUTER = 4'd5;  // load cur for insertion sort
   localparam logic [3:0] S_SINNER = 4'd6;  // compare and move one entry
   localparam logic [3:0] S_DONE   = 4'd7;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_ff, k_in;     // walking index
   logic [CNT_W-1:0] i_ff, i_in;     // sort outer index
   logic             rd_ff, rd_in;   // a read is in flight
   req_type          req_ff, req_in;
   logic [31:0]      cur_ff, cur_in;
   rsp_type          out_ff, out_in;
   logic             ov_ff, ov_in;
   mem_ctl_type      mc;

   logic [CNT_W-1:0] pos_ext;
   assign pos_ext = CNT_W'(req_data.position);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      k_in = k_ff;
      i_in = i_ff;
      rd_in = 1'b0;
      req_in = req_ff;
      cur_in = cur_ff;
      out_in = out_ff;
      ov_in = ov_ff;
      mc = '0;
      if (ov_ff && rsp_ready) begin
         ov_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !ov_ff) begin
               req_in = req_data;
               out_in = '0;
               out_in.status = ST_OK;
               state_in = S_DONE;
               case (req_data.operation)
                  OP_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        out_in.status = ST_FULL;
                     end else if (pos_ext > count_ff) begin
                        out_in.status = ST_BADPOS;
                     end else begin
                        k_in = count_ff;
                        state_in = S_INS;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        out_in.status = ST_EMPTY;
                     end else if (pos_ext >= count_ff) begin
                        out_in.status = ST_BADPOS;
                     end else begin
                        k_in = pos_ext;
                        state_in = S_DROP;
                     end
                  end
                  OP_REMKEY, OP_SEARCH: begin
                     if (count_ff == '0) begin
                        out_in.status = ST_EMPTY;
                     end else begin
                        k_in = '0;
                        state_in = S_FIND;
                     end
                  end
                  OP_SORT: begin
                     if (count_ff == '0) begin
                        out_in.status = ST_EMPTY;
                     end else begin
                        i_in = CNT_W'(1);
                        state_in = S_SOUTER;
                     end
                  end
                  OP_READ: begin
                     if (count_ff == '0) begin
                        out_in.status = ST_EMPTY;
                     end else if (pos_ext >= count_ff) begin
                        out_in.status = ST_BADPOS;
                     end else begin
                        mc.raddr = IDX_W'(pos_ext);
                        rd_in = 1'b1;
                        state_in = S_READ;
                     end
                  end
                  default: out_in.status = ST_BADPOS;
               endcase
            end
         end
         S_INS: begin
            // k walks from count down to position; entry k takes entry k-1.
            if (k_ff == CNT_W'(req_ff.position)) begin
               mc.we = 1'b1;
               mc.waddr = IDX_W'(k_ff);
               mc.wdata = req_ff.value;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else if (!rd_ff) begin
               mc.raddr = IDX_W'(k_ff - 1'b1);
               rd_in = 1'b1;
            end else begin
               mc.we = 1'b1;
               mc.waddr = IDX_W'(k_ff);
               mc.wdata = mem_rdata;
               k_in = k_ff - 1'b1;
            end
         end
         S_DROP: begin
            if (k_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else if (!rd_ff) begin
               mc.raddr = IDX_W'(k_ff + 1'b1);
               rd_in = 1'b1;
            end else begin
               mc.we = 1'b1;
               mc.waddr = IDX_W'(k_ff);
               mc.wdata = mem_rdata;
               k_in = k_ff + 1'b1;
            end
         end
         S_FIND: begin
            if (!rd_ff) begin
               if (k_ff >= count_ff) begin
                  out_in.status = ST_NOTFOUND;
                  state_in = S_DONE;
               end else begin
                  mc.raddr = IDX_W'(k_ff);
                  rd_in = 1'b1;
               end
            end else if (mem_rdata == req_ff.value) begin
               out_in.found_position = 7'(k_ff);
               if (req_ff.operation == OP_REMKEY) begin
                  state_in = S_DROP;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_READ: begin
            out_in.read_value = mem_rdata;
            state_in = S_DONE;
         end
         S_SOUTER: begin
            if (i_ff >= count_ff) begin
               state_in = S_DONE;
            end else if (!rd_ff) begin
               mc.raddr = IDX_W'(i_ff);
               rd_in = 1'b1;
            end else begin
               cur_in = mem_rdata;
               k_in = i_ff;
               state_in = S_SINNER;
            end
         end
         S_SINNER: begin
            if (k_ff == '0) begin
               mc.we = 1'b1;
               mc.waddr = IDX_W'(k_ff);
               mc.wdata = cur_ff;
               i_in = i_ff + 1'b1;
               state_in = S_SOUTER;
            end else if (!rd_ff) begin
               mc.raddr = IDX_W'(k_ff - 1'b1);
               rd_in = 1'b1;
            end else if ($signed(mem_rdata) > $signed(cur_ff)) begin
               mc.we = 1'b1;
               mc.waddr = IDX_W'(k_ff);
               mc.wdata = mem_rdata;
               k_in = k_ff - 1'b1;
            end else begin
               mc.we = 1'b1;
               mc.waddr = IDX_W'(k_ff);
               mc.wdata = cur_ff;
               i_in = i_ff + 1'b1;
               state_in = S_SOUTER;
            end
         end
         S_DONE: begin
            out_in.entry_count = 8'(count_ff);
            ov_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ov_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff <= ov_in;
         rd_ff <= rd_in;
      end
      k_ff <= k_in;
      i_ff <= i_in;
      req_ff <= req_in;
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;
   assign mem_ctl = mc;

   `PLSE_ASSERT(a_cnt_cap, clock, reset, count_ff <= CNT_W'(CAPACITY), "count over capacity")
   `PLSE_ASSERT(a_ready_idle, clock, reset, req_ready |-> !rsp_valid, "ready with result pending")
   `PLSE_ASSERT(a_done_valid, clock, reset, (state_ff == S_DONE) |=> rsp_valid, "done without result")
   `PLSE_ASSERT_NR(a_reset, clock, reset |=> (state_ff == S_IDLE && !rsp_valid), "reset state")
endmodule

FILE: rtl/core/positional_list_sort_engine.sv
// Channel   Direction  Payload              Handshake
// req_      in         plse_pkg::req_type   req_valid / req_ready
// rsp_      out        plse_pkg::rsp_type   rsp_valid / rsp_ready
// One transaction at a time; insert, remove and search walk the entries one by one
// through the RAM's single read port, and sort runs an insertion sort over them.
// Synchronous reset empties the list; RAM contents are not cleared.
// A result held on rsp_ blocks the next request until taken.
module positional_list_sort_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  plse_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output plse_pkg::rsp_type rsp_data
);
   import plse_pkg::*;

   mem_ctl_type mem_ctl;
   logic [31:0] mem_rdata;

   plse_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .mem_ctl(mem_ctl), .mem_rdata(mem_rdata)
   );

   plse_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .we(mem_ctl.we), .waddr(mem_ctl.waddr),
      .wdata(mem_ctl.wdata), .raddr(mem_ctl.raddr), .rdata(mem_rdata)
   );
endmodule

FILE: tb/positional_list_sort_engine_tb.sv
`timescale 1ns / 1ps

module positional_list_sort_engine_tb;
   import plse_pkg::*;

   localparam int STALL_LIMIT = 300000;

   // Tracks the list contents and the results the engine owes.
   class list_scoreboard;
      logic signed [31:0] entries[CAPACITY];
      int                 count;
      rsp_type            owed[$];
      int                 errors;

      function new();
         count = 0;
         errors = 0;
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
         errors++;
      endtask

      function void shift_down(int p);
         for (int k = p; k < count - 1; k++) entries[k] = entries[k + 1];
         count--;
      endfunction

      function void note(req_type r);
         rsp_type e;
         int      where;
         logic signed [31:0] cur;
         int      j;
         e = '0;
         e.status = ST_OK;
         where = -1;
         case (r.operation)
            OP_INSERT: begin
               if (count >= CAPACITY) e.status = ST_FULL;
               else if (r.position > count) e.status = ST_BADPOS;
               else begin
                  for (int k = count; k > r.position; k--) entries[k] = entries[k - 1];
                  entries[r.position] = r.value;
                  count++;
               end
            end
            OP_REMOVE: begin
               if (count == 0) e.status = ST_EMPTY;
               else if (r.position >= count) e.status = ST_BADPOS;
               else shift_down(r.position);
            end
            OP_REMKEY, OP_SEARCH: begin
               if (count == 0) e.status = ST_EMPTY;
               else begin
                  for (int k = 0; k < count; k++)
                     if (where < 0 && entries[k] == r.value) where = k;
                  if (where < 0) e.status = ST_NOTFOUND;
                  else begin
                     e.found_position = where[6:0];
                     if (r.operation == OP_REMKEY) shift_down(where);
                  end
               end
            end
            OP_SORT: begin
               if (count == 0) e.status = ST_EMPTY;
               else begin
                  for (int i = 1; i < count; i++) begin
                     cur = entries[i];
                     j = i;
                     while (j > 0 && entries[j - 1] > cur) begin
                        entries[j] = entries[j - 1];
                        j--;
                     end
                     entries[j] = cur;
                  end
               end
            end
            OP_READ: begin
               if (count == 0) e.status = ST_EMPTY;
               else if (r.position >= count) e.status = ST_BADPOS;
               else e.read_value = entries[r.position];
            end
            default: e.status = ST_BADPOS;
         endcase
         e.entry_count = count[7:0];
         owed.push_back(e);
      endfunction

      task check(rsp_type got);
         rsp_type e;
         if (owed.size() == 0) begin
            report("unexpected transaction", got[31:0], '0);
            return;
         end
         e = owed.pop_front();
         if (got.status !== e.status)
            report("status", 32'(got.status), 32'(e.status));
         if (got.read_value !== e.read_value)
            report("read_value", got.read_value, e.read_value);
         if (got.found_position !== e.found_position)
            report("found_position", 32'(got.found_position), 32'(e.found_position));
         if (got.entry_count !== e.entry_count)
            report("entry_count", 32'(got.entry_count), 32'(e.entry_count));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   list_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;

   positional_list_sort_engine DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("positional_list_sort_engine_tb: errors");
         $finish;
      end
   end

   // Presents one transaction and returns at the edge where it is accepted.
   task automatic send(logic [2:0] op, logic [6:0] pos, logic signed [31:0] val);
      req_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      r.operation = op;
      r.position = pos;
      r.value = val;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      board.note(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2, 3, 4: return $signed($urandom_range(15)) - 8;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic logic signed [31:0] pick_key();
      if (board.count > 0 && $urandom_range(99) < 70)
         return board.entries[$urandom_range(board.count - 1)];
      return pick_value();
   endfunction

   function automatic logic [6:0] pick_pos(int limit);
      if (limit >= 0 && $urandom_range(99) < 85) return 7'($urandom_range(limit));
      return 7'($urandom_range(127));
   endfunction

   // One random transaction; the list is steered toward a target length.
   task automatic random_item(int target);
      int dice;
      dice = $urandom_range(99);
      if (board.count < target) dice = (dice < 60) ? 0 : dice;
      else if (board.count > target + 4) dice = (dice < 50) ? 40 : dice;
      if (dice < 35) send(OP_INSERT, pick_pos(board.count), pick_value());
      else if (dice < 47) send(OP_REMOVE, pick_pos(board.count - 1), pick_value());
      else if (dice < 57) send(OP_REMKEY, pick_pos(127), pick_key());
      else if (dice < 72) send(OP_SEARCH, pick_pos(127), pick_key());
      else if (dice < 75) send(OP_SORT, pick_pos(127), pick_value());
      else if (dice < 98) send(OP_READ, pick_pos(board.count - 1), pick_value());
      else send(3'($urandom_range(7, 6)), pick_pos(127), pick_value());
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      quiet_cycles = 0;
      send_idle_pct = 7;
      recv_idle_pct = 59;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every operation on an empty list, then the edges of each field.
      send(OP_READ, 7'd0, 32'sd0);
      send(OP_REMOVE, 7'd0, 32'sd0);
      send(OP_REMKEY, 7'd0, 32'sd5);
      send(OP_SEARCH, 7'd0, 32'sd5);
      send(OP_SORT, 7'd0, 32'sd0);
      send(OP_INSERT, 7'd1, 32'sd9);
      send(OP_INSERT, 7'd0, 32'sh7fffffff);
      send(OP_INSERT, 7'd0, 32'sh80000000);
      send(OP_INSERT, 7'd2, 32'sd0);
      send(OP_INSERT, 7'd1, -32'sd1);
      send(OP_INSERT, 7'd127, 32'sd3);
      send(OP_READ, 7'd4, 32'sd0);
      send(OP_READ, 7'd127, 32'sd0);
      send(OP_READ, 7'd1, 32'sd0);
      send(OP_SEARCH, 7'd0, 32'sd42);
      send(OP_SEARCH, 7'd0, 32'sh80000000);
      send(OP_REMKEY, 7'd0, 32'sd42);
      send(OP_REMOVE, 7'd4, 32'sd0);
      send(OP_SORT, 7'd0, 32'sd0);
      send(OP_READ, 7'd0, 32'sd0);
      send(OP_READ, 7'd3, 32'sd0);
      send(3'd6, 7'h55, 32'sh55555555);
      send(3'd7, 7'h2a, 32'shaaaaaaaa);
      send(OP_REMKEY, 7'd0, 32'sh7fffffff);
      send(OP_REMOVE, 7'd0, 32'sd0);
      wait_drained();

      for (int n = 0; n < 500; n++) random_item((n / 50) % 2 ? 40 : 8);
      send_idle_pct = 59;
      recv_idle_pct = 7;
      for (int n = 0; n < 500; n++) random_item((n / 50) % 2 ? 6 : 30);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // Fill the list to capacity, overflow it and sort it while full.
      while (board.count < CAPACITY) send(OP_INSERT, pick_pos(board.count), pick_value());
      send(OP_INSERT, 7'd0, 32'sd1);
      send(OP_SORT, 7'd0, 32'sd0);
      send(OP_READ, 7'd127, 32'sd0);
      send(OP_INSERT, 7'd127, 32'sd1);
      send(OP_REMOVE, 7'd127, 32'sd0);
      for (int n = 0; n < 420; n++) random_item((n / 60) % 2 ? 12 : 50);

      wait_drained();
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.owed.size() == 0)
         $display("positional_list_sort_engine_tb: clean");
      else
         $display("positional_list_sort_engine_tb: errors");
      $finish;
   end
endmodule
